FILE: rtl/sbsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sbsh_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS = 64;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned WIN_WORDS = 16;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam logic [1:0] BSEL_DATA = 2'd0;
  localparam logic [1:0] BSEL_PAD = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN = 2'd3;

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       shift_en;
    logic [1:0] byte_sel;
    logic [2:0] len_idx;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       vars_load;
    logic       round_en;
    logic [5:0] rnd;
    logic       hash_add;
    logic       hash_pop;
    logic [2:0] pop_idx;
  } sbsh_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/sbsh_ctrl.sv
// Sequencer for absorb, padding, compression rounds and digest output.
module sbsh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_op,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_tlast,
  output sbsh_pkg::sbsh_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       pad_r, pad_nxt;
  logic       first_r, first_nxt;
  logic       lastblk_r, lastblk_nxt;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    rnd_nxt     = rnd_r;
    oidx_nxt    = oidx_r;
    pad_nxt     = pad_r;
    first_nxt   = first_r;
    lastblk_nxt = lastblk_r;
    cmd          = '0;
    cmd.byte_sel = sbsh_pkg::BSEL_DATA;
    cmd.len_idx  = pos_r[2:0];
    cmd.rnd      = rnd_r;
    cmd.pop_idx  = oidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == sbsh_pkg::OP_ABSORB) begin
            cmd.shift_en = 1'b1;
            cmd.cnt_inc  = 1'b1;
            pos_nxt      = pos_r + 6'd1;
            if (pos_r == sbsh_pkg::LAST_POS) begin
              cmd.vars_load = 1'b1;
              rnd_nxt       = '0;
              state_nxt     = S_ROUND;
            end
          end else begin
            pad_nxt     = 1'b1;
            first_nxt   = 1'b1;
            lastblk_nxt = (pos_r < sbsh_pkg::LEN_POS);
            state_nxt   = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (first_r) begin
          cmd.byte_sel = sbsh_pkg::BSEL_PAD;
        end else if (lastblk_r && (pos_r >= sbsh_pkg::LEN_POS)) begin
          cmd.byte_sel = sbsh_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = sbsh_pkg::BSEL_ZERO;
        end
        first_nxt = 1'b0;
        pos_nxt   = pos_r + 6'd1;
        if (pos_r == sbsh_pkg::LAST_POS) begin
          cmd.vars_load = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == sbsh_pkg::LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.hash_add = 1'b1;
        if (!pad_r) begin
          state_nxt = S_IDLE;
        end else if (lastblk_r) begin
          cmd.cnt_clr = 1'b1;
          pad_nxt     = 1'b0;
          oidx_nxt    = '0;
          state_nxt   = S_OUT;
        end else begin
          lastblk_nxt = 1'b1;
          state_nxt   = S_PAD;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.hash_pop = 1'b1;
          oidx_nxt     = oidx_r + 3'd1;
          if (oidx_r == sbsh_pkg::LAST_WORD) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (oidx_r == sbsh_pkg::LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      rnd_r     <= '0;
      oidx_r    <= '0;
      pad_r     <= 1'b0;
      first_r   <= 1'b0;
      lastblk_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      rnd_r     <= rnd_nxt;
      oidx_r    <= oidx_nxt;
      pad_r     <= pad_nxt;
      first_r   <= first_nxt;
      lastblk_r <= lastblk_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output channels active together");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == sbsh_pkg::LAST_ROUND) |=> (state_r == S_ADD))
    else $error("round sequence did not end in hash update");

  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == sbsh_pkg::OP_ABSORB && pos_r == sbsh_pkg::LAST_POS)
    |=> (state_r == S_ROUND && rnd_r == '0 && pos_r == '0))
    else $error("full block did not start compression");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && pos_r == '0))
    else $error("block not idle after last digest item");
`endif

endmodule

FILE: rtl/sbsh_dp.sv
// Datapath: byte window and message schedule, round variables, hash words, bit count.
module sbsh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sbsh_pkg::sbsh_cmd_t cmd,
  input  logic [7:0]          in_byte,
  output logic [31:0]         digest_word
);

  logic [31:0] w_r [sbsh_pkg::WIN_WORDS];
  logic [31:0] w_nxt [sbsh_pkg::WIN_WORDS];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] hash_r [sbsh_pkg::HASH_WORDS];
  logic [31:0] hash_nxt [sbsh_pkg::HASH_WORDS];
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic [7:0]  byte_val;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    case (cmd.byte_sel)
      sbsh_pkg::BSEL_PAD:  byte_val = sbsh_pkg::PAD_BYTE;
      sbsh_pkg::BSEL_ZERO: byte_val = 8'h00;
      sbsh_pkg::BSEL_LEN:  byte_val = bitcnt_r[8 * (7 - int'(cmd.len_idx)) +: 8];
      default:             byte_val = in_byte;
    endcase
  end

  assign w_new = sbsh_pkg::ssig1(w_r[14]) + w_r[9] + sbsh_pkg::ssig0(w_r[1]) + w_r[0];
  assign t1 = v_r[7] + sbsh_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sbsh_pkg::ROUND_K[cmd.rnd] + w_r[0];
  assign t2 = sbsh_pkg::bsig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    for (int i = 0; i < sbsh_pkg::WIN_WORDS; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (cmd.shift_en) begin
      for (int i = 0; i < sbsh_pkg::WIN_WORDS - 1; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i + 1][31:24]};
      end
      w_nxt[sbsh_pkg::WIN_WORDS - 1] = {w_r[sbsh_pkg::WIN_WORDS - 1][23:0], byte_val};
    end else if (cmd.round_en) begin
      for (int i = 0; i < sbsh_pkg::WIN_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[sbsh_pkg::WIN_WORDS - 1] = w_new;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      v_nxt[i] = v_r[i];
    end
    if (cmd.vars_load) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = hash_r[i];
      end
    end else if (cmd.round_en) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
      hash_nxt[i] = hash_r[i];
    end
    if (cmd.hash_add) begin
      for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end else if (cmd.hash_pop) begin
      for (int i = 0; i < sbsh_pkg::HASH_WORDS - 1; i++) begin
        hash_nxt[i] = hash_r[i + 1];
      end
      hash_nxt[sbsh_pkg::HASH_WORDS - 1] = sbsh_pkg::INIT_HASH[cmd.pop_idx];
    end
  end

  always_comb begin
    bitcnt_nxt = bitcnt_r;
    if (cmd.cnt_clr) begin
      bitcnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      bitcnt_nxt = bitcnt_r + 64'd8;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sbsh_pkg::WIN_WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
    for (int i = 0; i < 8; i++) begin
      v_r[i] <= v_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= sbsh_pkg::INIT_HASH[i];
      end
      bitcnt_r <= '0;
    end else begin
      for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
      bitcnt_r <= bitcnt_nxt;
    end
  end

  assign digest_word = hash_r[0];

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: absorbs one byte per item and emits the 8-word digest.
// Absorb item: the 64th byte of a block starts the 64 rounds and the hash update.
// Finish item: padding fills the rest of the block, which is then compressed; a second padded block
// is compressed when 56 or more bytes are in the block; then 8 digest items follow.
// A single shared round unit compresses each block; no bytes are taken until the hash update ends.
// Synchronous active-low reset loads the initial hash values and clears length and count.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast
);

  sbsh_pkg::sbsh_cmd_t cmd;

  sbsh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd)
  );

  sbsh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .digest_word (out_tdata)
  );

endmodule
